FILE: sv/base64_custom_alphabet_encoder_assert.svh
// ----------------------------------------------------------------------------
// base64 custom alphabet encoder assertion macros
// shared assertion forms, all clocked on clk and disabled while rst_n is low
// ----------------------------------------------------------------------------
`ifndef BASE64_CUSTOM_ALPHABET_ENCODER_ASSERT_SVH
`define BASE64_CUSTOM_ALPHABET_ENCODER_ASSERT_SVH

// same-cycle implication
`define B64CAE_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define B64CAE_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: sv/b64cae_pkg.sv
// ----------------------------------------------------------------------------
// b64cae_pkg
// shared types, constants and the symbol lookup of the base64 encoder
// ----------------------------------------------------------------------------
package b64cae_pkg;

    // result queue sizing, one byte may need two free entries
    localparam int QDEPTH = 4;
    localparam int QPTR_W = $clog2(QDEPTH);
    localparam int QCNT_W = $clog2(QDEPTH + 1);

    localparam int BYTE_W = 8;
    localparam int SEXT_W = 6;
    localparam int CHAR_W = 7;

    // number of leftover bits carried between bytes
    typedef enum logic [1:0] {
        PH_0 = 2'd0,
        PH_2 = 2'd1,
        PH_4 = 2'd2
    } phase_t;

    // characters produced by one byte, handed to the result queue
    typedef struct packed {
        logic              push;
        logic              two;
        logic [CHAR_W-1:0] char0;
        logic [CHAR_W-1:0] char1;
        logic              last1;
    } pair_t;

    // 6-bit value to ascii: digits, upper case, lower case, '$', '@'
    function automatic logic [CHAR_W-1:0] sym_char(input logic [SEXT_W-1:0] v);
        logic [CHAR_W-1:0] c;
        if (v < 6'd10)
            c = 7'h30 + {1'b0, v};
        else if (v < 6'd36)
            c = 7'h41 + {1'b0, v - 6'd10};
        else if (v < 6'd62)
            c = 7'h61 + {1'b0, v - 6'd36};
        else if (v == 6'd62)
            c = 7'h24;
        else
            c = 7'h40;
        return c;
    endfunction

endpackage

FILE: sv/base64_custom_alphabet_encoder.sv
// ----------------------------------------------------------------------------
// base64_custom_alphabet_encoder
// streaming base64 encoder with a 64-symbol custom alphabet and no padding
// ----------------------------------------------------------------------------
// Message bytes enter on the s_ side, most significant bit first, with
// s_tlast on the final byte; ascii characters leave on the m_ side, one per
// ready cycle, with m_tlast on the last one. Alphabet: '0'-'9', 'A'-'Z',
// 'a'-'z', '$', '@'; the tail is zero padded to one character, no '='.
// Each byte gives one or two characters in one pass of logic into a
// four-entry result queue; a byte is taken whenever two entries are free,
// so a new byte can be accepted while earlier characters still wait in the
// queue. Characters are registered in the queue before they leave on m_.

module base64_custom_alphabet_encoder
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic [7:0] s_tdata,   // [7:0] data_byte
    input  logic       s_tlast,   // end_of_message
    output logic       m_tvalid,
    input  logic       m_tready,
    output logic [7:0] m_tdata,   // [6:0] symbol_char, [7] zero
    output logic       m_tlast    // last_symbol
);

    b64cae_pkg::pair_t pair;
    logic              room;
    logic              take;

    // accept a byte request while two queue entries are free
    assign s_tready = room;
    assign take     = s_tvalid && room;

    b64cae_regroup u_regroup
    (
        .clk            (clk),
        .rst_n          (rst_n),
        .take           (take),
        .data_byte      (s_tdata),
        .end_of_message (s_tlast),
        .pair           (pair)
    );

    b64cae_outq u_outq
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .pair     (pair),
        .room     (room),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

endmodule

FILE: sv/b64cae_regroup.sv
// ----------------------------------------------------------------------------
// b64cae_regroup
// regroups each byte with the carried bits into one or two characters
// ----------------------------------------------------------------------------
`include "base64_custom_alphabet_encoder_assert.svh"

module b64cae_regroup
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                take,        // byte request accepted this cycle
    input  logic [7:0]          data_byte,
    input  logic                end_of_message,
    output b64cae_pkg::pair_t   pair
);

    b64cae_pkg::phase_t phase_reg, phase_next;
    logic [3:0]         bits_reg, bits_next;
    logic [5:0]         v0, v1;
    logic               two;

    // carried bits and phase
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= b64cae_pkg::PH_0;
            bits_reg  <= 4'd0;
        end
        else if (take)
        begin
            phase_reg <= phase_next;
            bits_reg  <= bits_next;
        end
    end

    // split the byte according to how many bits are held
    always_comb
    begin
        unique case (phase_reg)
            b64cae_pkg::PH_2:
            begin
                v0         = {bits_reg[1:0], data_byte[7:4]};
                v1         = {data_byte[3:0], 2'b00};
                two        = end_of_message;
                phase_next = b64cae_pkg::PH_4;
                bits_next  = data_byte[3:0];
            end
            b64cae_pkg::PH_4:
            begin
                v0         = {bits_reg, data_byte[7:6]};
                v1         = data_byte[5:0];
                two        = 1'b1;
                phase_next = b64cae_pkg::PH_0;
                bits_next  = 4'd0;
            end
            default:
            begin
                v0         = data_byte[7:2];
                v1         = {data_byte[1:0], 4'b0000};
                two        = end_of_message;
                phase_next = b64cae_pkg::PH_2;
                bits_next  = {2'b00, data_byte[1:0]};
            end
        endcase
        // flush returns to the start of a new message
        if (end_of_message)
        begin
            phase_next = b64cae_pkg::PH_0;
            bits_next  = 4'd0;
        end
    end

    // characters for the queue
    always_comb
    begin
        pair.push  = take;
        pair.two   = two;
        pair.char0 = b64cae_pkg::sym_char(v0);
        pair.char1 = b64cae_pkg::sym_char(v1);
        pair.last1 = end_of_message;
    end

    `B64CAE_ASSERT_NXT(a_flush_resets, take && end_of_message, phase_reg == b64cae_pkg::PH_0 && bits_reg == 4'd0, "phase not cleared after end of message")
    `B64CAE_ASSERT_IMP(a_ph4_two, take && phase_reg == b64cae_pkg::PH_4, pair.two, "four held bits must give two characters")
    `B64CAE_ASSERT_IMP(a_ph0_bits, phase_reg == b64cae_pkg::PH_0, bits_reg == 4'd0, "bits held with empty phase")

endmodule

FILE: sv/b64cae_outq.sv
// ----------------------------------------------------------------------------
// b64cae_outq
// small result queue, takes one or two characters and sends one a cycle while m_tready is high
// ----------------------------------------------------------------------------
`include "base64_custom_alphabet_encoder_assert.svh"

module b64cae_outq
(
    input  logic                clk,
    input  logic                rst_n,
    input  b64cae_pkg::pair_t   pair,
    output logic                room,        // space for two characters
    output logic                m_tvalid,
    input  logic                m_tready,
    output logic [7:0]          m_tdata,
    output logic                m_tlast
);

    localparam int QDEPTH = b64cae_pkg::QDEPTH;
    localparam int QPTR_W = b64cae_pkg::QPTR_W;
    localparam int QCNT_W = b64cae_pkg::QCNT_W;
    localparam int CHAR_W = b64cae_pkg::CHAR_W;

    logic [CHAR_W:0]   q_reg [QDEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0] count_reg, count_next;
    logic [1:0]        n_push;
    logic              pop;

    assign pop    = (count_reg != '0) && m_tready;
    assign n_push = pair.push ? (pair.two ? 2'd2 : 2'd1) : 2'd0;
    assign room   = count_reg <= QCNT_W'(QDEPTH - 2);

    // pointer and fill arithmetic
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg + QPTR_W'(n_push);
        rd_ptr_next = rd_ptr_reg + QPTR_W'(pop);
        count_next  = count_reg + QCNT_W'(n_push) - QCNT_W'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // queue entries, first character is never the last one
    always_ff @(posedge clk)
    begin
        if (pair.push)
        begin
            q_reg[wr_ptr_reg] <= {1'b0, pair.char0};
            if (pair.two)
                q_reg[wr_ptr_reg + QPTR_W'(1)] <= {pair.last1, pair.char1};
        end
    end

    // head of the queue drives the result port
    assign m_tvalid = count_reg != '0;
    assign m_tdata  = {1'b0, q_reg[rd_ptr_reg][CHAR_W-1:0]};
    assign m_tlast  = q_reg[rd_ptr_reg][CHAR_W];

    `B64CAE_ASSERT_IMP(a_no_overflow, 1'b1, count_reg <= QCNT_W'(QDEPTH), "queue fill beyond depth")
    `B64CAE_ASSERT_IMP(a_push_room, pair.push, room, "characters pushed without room")
    `B64CAE_ASSERT_NXT(a_pop_step, pop && !pair.push, count_reg == $past(count_reg) - QCNT_W'(1), "fill did not drop after a sent character")

endmodule

FILE: tb/base64_custom_alphabet_encoder_test.sv
// ----------------------------------------------------------------------------
// base64_custom_alphabet_encoder_test
// Byte stream in, ASCII symbols out: every accepted byte is run through a
// local bit-regrouping model. The symbols it should give are queued and each
// symbol leaving the block is checked against the oldest of them. Directed
// messages cover alphabet boundaries and every tail length, then random
// messages run under bursty requests and several receiver stall patterns.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module base64_custom_alphabet_encoder_test;

    localparam int WATCHDOG_LIMIT = 4000;
    localparam int MAX_REPORTS    = 10;

    typedef enum logic [1:0] {
        RX_OPEN,
        RX_RANDOM,
        RX_PATTERN,
        RX_LONG
    } rx_mode_t;

    typedef struct packed {
        logic [b64cae_pkg::CHAR_W-1:0] symbol;
        logic                          is_last;
    } symbol_t;

    logic       clk;
    logic       rst_n;
    logic       s_tvalid;
    logic       s_tready;
    logic [7:0] s_tdata;   // [7:0] data_byte
    logic       s_tlast;   // end_of_message
    logic       m_tvalid;
    logic       m_tready;
    logic [7:0] m_tdata;   // [6:0] symbol_char, [7] zero
    logic       m_tlast;   // last_symbol

    // model state of the encoder
    b64cae_pkg::phase_t held_phase;
    logic [3:0] held_bits;
    string      alphabet = "0123456789ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz$@";

    symbol_t    pending_symbols[$];
    int         mismatch_count;
    int         idle_cycles;
    int         burst_left;
    bit         smooth_sender;
    rx_mode_t   rx_mode;
    int         rx_tick;
    int         stall_left;

    base64_custom_alphabet_encoder DUT
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

    // 50 MHz clock
    initial clk = 1'b0;
    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // 6-bit value to its alphabet character
    function automatic logic [b64cae_pkg::CHAR_W-1:0] sextet_char(input logic [5:0] v);
        byte c;
        c = alphabet[v];
        return c[b64cae_pkg::CHAR_W-1:0];
    endfunction

    function automatic void queue_symbol(input logic [5:0] v, input logic is_last);
        symbol_t s;
        s.symbol  = sextet_char(v);
        s.is_last = is_last;
        pending_symbols.push_back(s);
    endfunction

    // regroup one byte with the held bits into symbols
    function automatic void encode_byte(input logic [7:0] b, input logic eom);
        case (held_phase)
            b64cae_pkg::PH_2:
            begin
                queue_symbol({held_bits[1:0], b[7:4]}, 1'b0);
                if (eom)
                    queue_symbol({b[3:0], 2'b00}, 1'b1);
                held_bits  = b[3:0];
                held_phase = b64cae_pkg::PH_4;
            end
            b64cae_pkg::PH_4:
            begin
                queue_symbol({held_bits, b[7:6]}, 1'b0);
                queue_symbol(b[5:0], eom);
                held_bits  = 4'd0;
                held_phase = b64cae_pkg::PH_0;
            end
            default:
            begin
                queue_symbol(b[7:2], 1'b0);
                if (eom)
                    queue_symbol({b[1:0], 4'b0000}, 1'b1);
                held_bits  = {2'b00, b[1:0]};
                held_phase = b64cae_pkg::PH_2;
            end
        endcase
        // a message end clears the carry
        if (eom)
        begin
            held_bits  = 4'd0;
            held_phase = b64cae_pkg::PH_0;
        end
    endfunction

    // request side feeds the model, result side checks against it
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (s_tvalid && s_tready)
                encode_byte(s_tdata, s_tlast);
            if (m_tvalid && m_tready)
            begin
                if (pending_symbols.size() == 0)
                begin
                    mismatch_count++;
                    if (mismatch_count <= MAX_REPORTS)
                        $display("unexpected symbol: tdata=%h tlast=%b", m_tdata, m_tlast);
                end
                else
                begin
                    symbol_t want;
                    want = pending_symbols.pop_front();
                    if (m_tdata !== {1'b0, want.symbol} || m_tlast !== want.is_last)
                    begin
                        mismatch_count++;
                        if (mismatch_count <= MAX_REPORTS)
                            $display({"symbol mismatch: expected char=%h last=%b, ",
                                      "got tdata=%h tlast=%b"},
                                     want.symbol, want.is_last, m_tdata, m_tlast);
                    end
                end
            end
        end
    end

    // receiver stall patterns
    always @(negedge clk)
    begin
        rx_tick++;
        case (rx_mode)
            RX_OPEN:    m_tready <= 1'b1;
            RX_RANDOM:  m_tready <= ($urandom_range(0, 3) != 0);
            RX_PATTERN: m_tready <= (rx_tick % 7 != 2) && (rx_tick % 5 != 0);
            default:
            begin
                if (stall_left > 0)
                begin
                    stall_left--;
                    m_tready <= 1'b0;
                end
                else if ($urandom_range(0, 9) == 0)
                begin
                    stall_left = $urandom_range(5, 40);
                    m_tready <= 1'b0;
                end
                else
                    m_tready <= 1'b1;
            end
        endcase
    end

    // watchdog on cycles with no request or result accepted
    always @(posedge clk)
    begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || !rst_n)
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("** base64_custom_alphabet_encoder: FAILED **");
            $finish;
        end
    end

    // bursts of requests with random gaps, noise on the bus in the gaps
    task automatic pace_sender();
        int gap;
        if (burst_left == 0)
        begin
            if (!smooth_sender)
            begin
                gap = ($urandom_range(0, 3) == 0) ? $urandom_range(6, 25) : $urandom_range(0, 4);
                if (gap > 0)
                begin
                    s_tvalid <= 1'b0;
                    s_tdata  <= 8'($urandom);
                    s_tlast  <= 1'($urandom);
                    repeat (gap) @(negedge clk);
                end
            end
            burst_left = $urandom_range(1, 12);
        end
        burst_left--;
    endtask

    // one request, called and returning at a falling edge
    task automatic send_byte(input logic [7:0] b, input logic eom);
        pace_sender();
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        s_tlast  <= eom;
        do
            @(posedge clk);
        while (!s_tready);
        @(negedge clk);
    endtask

    // hold requests until every symbol has arrived
    task automatic wait_drained();
        s_tvalid <= 1'b0;
        while (pending_symbols.size() != 0)
            @(posedge clk);
        @(negedge clk);
    endtask

    function automatic logic [7:0] random_byte();
        case ($urandom_range(0, 9))
            0:       return 8'h00;
            1:       return 8'hFF;
            default: return 8'($urandom);
        endcase
    endfunction

    task automatic send_random_message(input int len);
        for (int i = 0; i < len; i++)
            send_byte(random_byte(), i == len - 1);
    endtask

    // alphabet edges, extreme bytes, all three tail lengths
    task automatic test_directed();
        smooth_sender = 1'b1;
        rx_mode       = RX_OPEN;
        send_byte(8'h00, 1'b1);
        send_byte(8'hFF, 1'b1);
        send_byte(8'hFF, 1'b0);
        send_byte(8'hFF, 1'b1);
        send_byte(8'hFF, 1'b0);
        send_byte(8'hFF, 1'b0);
        send_byte(8'hFF, 1'b1);
        send_byte(8'h00, 1'b0);
        send_byte(8'h00, 1'b0);
        send_byte(8'h00, 1'b1);
        // symbols 9, 10, 35, 36, 61, 62, 63 from the top six bits
        send_byte(8'h24, 1'b1);
        send_byte(8'h28, 1'b1);
        send_byte(8'h8C, 1'b1);
        send_byte(8'h90, 1'b1);
        send_byte(8'hF4, 1'b1);
        send_byte(8'hF8, 1'b1);
        send_byte(8'hFC, 1'b1);
        // alternating bits through every carry phase
        send_byte(8'hAA, 1'b0);
        send_byte(8'h55, 1'b0);
        send_byte(8'hAA, 1'b0);
        send_byte(8'h55, 1'b1);
        wait_drained();
    endtask

    // random messages, mostly short, under changing stall patterns
    task automatic test_random_messages();
        int sent;
        int len;
        sent = 0;
        while (sent < 1200)
        begin
            len = ($urandom_range(0, 9) == 0) ? $urandom_range(13, 48) : $urandom_range(1, 12);
            smooth_sender = ($urandom_range(0, 4) == 0);
            rx_mode       = rx_mode_t'($urandom_range(0, 3));
            send_random_message(len);
            sent += len;
            // a full drain now and then
            if ($urandom_range(0, 15) == 0)
                wait_drained();
        end
        wait_drained();
    endtask

    // single-byte messages one after another, with random gaps
    task automatic test_single_byte_messages();
        smooth_sender = 1'b0;
        rx_mode       = RX_PATTERN;
        for (int i = 0; i < 200; i++)
            send_byte(random_byte(), 1'b1);
        wait_drained();
    endtask

    // long receiver stalls fill the result queue
    task automatic test_long_stalls();
        smooth_sender = 1'b1;
        rx_mode       = RX_LONG;
        for (int i = 0; i < 20; i++)
            send_random_message($urandom_range(1, 8));
        wait_drained();
    endtask

    // no idling on either side
    task automatic test_full_rate();
        smooth_sender = 1'b1;
        rx_mode       = RX_OPEN;
        for (int i = 0; i < 25; i++)
            send_random_message($urandom_range(3, 9));
        wait_drained();
    endtask

    initial
    begin
        rst_n          = 1'b0;
        s_tvalid       = 1'b0;
        s_tdata        = 8'h00;
        s_tlast        = 1'b0;
        m_tready       = 1'b0;
        held_phase     = b64cae_pkg::PH_0;
        held_bits      = 4'd0;
        mismatch_count = 0;
        idle_cycles    = 0;
        burst_left     = 0;
        smooth_sender  = 1'b1;
        rx_mode        = RX_OPEN;
        rx_tick        = 0;
        stall_left     = 0;
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        test_directed();
        test_random_messages();
        test_single_byte_messages();
        test_long_stalls();
        test_full_rate();

        repeat (10) @(posedge clk);
        if (mismatch_count == 0 && pending_symbols.size() == 0)
            $display("** base64_custom_alphabet_encoder: PASSED **");
        else
            $display("** base64_custom_alphabet_encoder: FAILED **");
        $finish;
    end

endmodule
